// ===== hdl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the triggered sample capture
// Operation and trigger codes, register indexes and the structs that
// travel between the control, store and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  // Buffer depth and derived widths
  localparam int DEPTH     = 16384;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int IDX_W     = 14;
  localparam int CNT_W     = 14;
  localparam int TIME_W    = 32;
  localparam int MODE_W    = 3;
  localparam int IVL_W     = 20;
  localparam int ENTRY_W   = TIME_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = IVL_W;
  localparam int CMP_W     = 32;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(1000);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    TRIG_NONE    = 3'd0,
    TRIG_RISING  = 3'd1,
    TRIG_FALLING = 3'd2,
    TRIG_BOTH    = 3'd3,
    TRIG_HIGH    = 3'd4,
    TRIG_LOW     = 3'd5
  } trig_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_MODE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 1'd1;

  // Status part of one result word
  typedef struct packed {
    logic             capturing;
    logic             trigger_armed;
    logic [CNT_W-1:0] entry_count;
    logic             auto_stopped;
    logic             read_valid;
  } res_t;

  // Sample store access for one accepted word
  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/tsc_if.sv =====
// ----------------------------------------------------------------------------
// tsc_in_if / tsc_out_if: valid/ready channels of the capture block
// Input words carry one operation; output words carry one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        pin_level;
  logic [13:0] read_index;

  modport source (output valid, output operation, output pin_level,
                  output read_index, input ready);
  modport sink   (input valid, input operation, input pin_level,
                  input read_index, output ready);
endinterface

interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic        capturing;
  logic        trigger_armed;
  logic [13:0] entry_count;
  logic        auto_stopped;
  logic        read_valid;
  logic        read_level;
  logic [31:0] read_time;

  modport source (output valid, output capturing, output trigger_armed,
                  output entry_count, output auto_stopped, output read_valid,
                  output read_level, output read_time, input ready);
  modport sink   (input valid, input capturing, input trigger_armed,
                  input entry_count, input auto_stopped, input read_valid,
                  input read_level, input read_time, output ready);
endinterface

`default_nettype wire

// ===== hdl/triggered_sample_capture.sv =====
// ----------------------------------------------------------------------------
// triggered_sample_capture: single-channel logic analyzer capture core
// Result path: accepted operation -> read stage -> output register -> result.
// Throughput: one operation per cycle unless the output stalls; the single
//   store write port and the registered read port serve one access each per cycle.
// Reset: synchronous; control state, counters and pipeline valid flags return
//   to reset values at once. The buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_sample_capture (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsc_pkg::CFG_W-1:0]     cfg_data,
  tsc_in_if.sink                             item,
  tsc_out_if.source                          result
);
  import tsc_pkg::*;

  logic               accept;
  logic               in_ready;
  res_t               res;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;

  // A word enters when the read stage is free or drains this cycle
  assign item.ready = in_ready;
  assign accept     = item.valid && in_ready;

  // Control state: time counter, trigger, interval and write pointer.
  // Store writes and reads are issued at the accept edge, so a read always
  // sees every sample written by earlier words without forwarding.
  tsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .operation  (item.operation),
    .pin_level  (item.pin_level),
    .read_index (item.read_index),
    .res        (res),
    .mem_req    (mem_req)
  );

  // Sample buffer: {time, level} per entry, registered read
  tsc_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Read stage plus output register; the output can stall while one more
  // word is taken into the read stage
  tsc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .rdata    (rdata),
    .in_ready (in_ready),
    .result   (result)
  );

  // Filling the buffer always ends capture
  a_stop_ends_capture: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.auto_stopped |-> !result.capturing)
    else $error("auto stop with capture still running");

  // Stored samples only come from an armed trigger
  a_stop_needs_armed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.auto_stopped |-> result.trigger_armed)
    else $error("buffer filled without an armed trigger");

  // Entry fields stay zero unless the read hit a stored entry
  a_read_gated: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.read_valid |-> result.read_time == '0 && !result.read_level)
    else $error("entry data shown on a word without a valid read");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result.valid && item.ready)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== hdl/tsc_store.sv =====
// ----------------------------------------------------------------------------
// tsc_store: sample buffer
// One write port and one registered read port; entries hold {time, level}.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_store (
  input  wire logic                        clk,
  input  wire tsc_pkg::mem_req_t           req,
  output logic [tsc_pkg::ENTRY_W-1:0]      rdata
);
  import tsc_pkg::*;

  logic [ENTRY_W-1:0] sample_store [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      sample_store[req.waddr] <= req.wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= sample_store[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsc_ctrl: capture control state
// Time counter, trigger, interval check and write pointer; issues store
// accesses and the status part of each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          accept,
  input  wire logic [1:0]                    operation,
  input  wire logic                          pin_level,
  input  wire logic [tsc_pkg::IDX_W-1:0]     read_index,
  output tsc_pkg::res_t                      res,
  output tsc_pkg::mem_req_t                  mem_req
);
  import tsc_pkg::*;

  logic [MODE_W-1:0] trig_mode;
  logic [IVL_W-1:0]  sample_interval;
  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic              running, running_next;
  logic              armed, armed_next;
  logic              previous_level, previous_level_next;
  logic [TIME_W-1:0] last_sample_time, last_sample_time_next;
  logic [TIME_W-1:0] time_counter, time_counter_next;

  op_t               op;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              fires;
  logic [PTR_W-1:0]  ptr_inc;
  logic              stopped_now;
  logic              rvalid;

  always_comb begin
    unique case (trig_t'(trig_mode))
      TRIG_RISING:  fires = !previous_level && pin_level;
      TRIG_FALLING: fires = previous_level && !pin_level;
      TRIG_BOTH:    fires = previous_level != pin_level;
      TRIG_HIGH:    fires = pin_level;
      TRIG_LOW:     fires = !pin_level;
      default:      fires = 1'b1;
    endcase
  end

  always_comb begin
    op       = op_t'(operation);
    time_inc = time_counter + TIME_W'(1);
    elapsed  = time_inc - last_sample_time;
    due      = running && (elapsed >= TIME_W'(sample_interval));
    ptr_inc  = (write_pointer == PTR_W'(DEPTH - 1)) ? '0 : write_pointer + PTR_W'(1);

    write_pointer_next    = write_pointer;
    running_next          = running;
    armed_next            = armed;
    previous_level_next   = previous_level;
    last_sample_time_next = last_sample_time;
    time_counter_next     = time_counter;
    stopped_now           = 1'b0;
    rvalid                = 1'b0;
    mem_req               = '0;

    unique case (op)
      OP_TICK: begin
        time_counter_next = time_inc;
        if (due) begin
          if (trig_mode != TRIG_NONE && !armed) begin
            // Trigger check only: drop the sample
            if (fires) begin
              armed_next = 1'b1;
            end
            previous_level_next = pin_level;
          end else begin
            mem_req.we            = accept;
            mem_req.waddr         = write_pointer;
            mem_req.wdata         = {time_inc, pin_level};
            write_pointer_next    = ptr_inc;
            last_sample_time_next = time_inc;
            previous_level_next   = pin_level;
            if (ptr_inc == PTR_W'(DEPTH - 1)) begin
              running_next = 1'b0;
              stopped_now  = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        write_pointer_next    = '0;
        armed_next            = (trig_mode == TRIG_NONE);
        last_sample_time_next = time_counter;
        running_next          = 1'b1;
      end
      OP_STOP: begin
        running_next = 1'b0;
      end
      OP_READ: begin
        rvalid = (CMP_W'(read_index) < CMP_W'(write_pointer)) &&
                 (CMP_W'(read_index) < CMP_W'(DEPTH));
        mem_req.re    = accept && rvalid;
        mem_req.raddr = PTR_W'(read_index);
      end
      default: ;
    endcase

    res.capturing     = running_next;
    res.trigger_armed = armed_next;
    res.entry_count   = CNT_W'(write_pointer_next);
    res.auto_stopped  = stopped_now;
    res.read_valid    = rvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_mode        <= TRIG_NONE;
      sample_interval  <= IVL_RESET;
      write_pointer    <= '0;
      running          <= 1'b0;
      armed            <= 1'b0;
      previous_level   <= 1'b0;
      last_sample_time <= '0;
      time_counter     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIG_MODE: begin
          trig_mode <= cfg_data[MODE_W-1:0];
          armed     <= (cfg_data[MODE_W-1:0] == TRIG_NONE);
        end
        CFG_SAMPLE_INTERVAL: begin
          sample_interval <= cfg_data[IVL_W-1:0];
        end
        default: ;
      endcase
    end else if (accept) begin
      write_pointer    <= write_pointer_next;
      running          <= running_next;
      armed            <= armed_next;
      previous_level   <= previous_level_next;
      last_sample_time <= last_sample_time_next;
      time_counter     <= time_counter_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tsc_outq.sv =====
// ----------------------------------------------------------------------------
// tsc_outq: result pipeline
// Read stage aligned with the store read data, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_outq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire tsc_pkg::res_t               res,
  input  wire logic [tsc_pkg::ENTRY_W-1:0] rdata,
  output logic                             in_ready,
  tsc_out_if.source                        result
);
  import tsc_pkg::*;

  logic              s1_valid;
  res_t              s1_res;
  logic              o_valid;
  res_t              o_res;
  logic              o_level;
  logic [TIME_W-1:0] o_time;
  logic              s1_move;

  assign s1_move  = s1_valid && (!o_valid || result.ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_move) begin
      o_res   <= s1_res;
      o_level <= s1_res.read_valid ? rdata[0] : 1'b0;
      o_time  <= s1_res.read_valid ? rdata[ENTRY_W-1:1] : '0;
    end
  end

  assign result.valid         = o_valid;
  assign result.capturing     = o_res.capturing;
  assign result.trigger_armed = o_res.trigger_armed;
  assign result.entry_count   = o_res.entry_count;
  assign result.auto_stopped  = o_res.auto_stopped;
  assign result.read_valid    = o_res.read_valid;
  assign result.read_level    = o_level;
  assign result.read_time     = o_time;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triggered sample capture core
// Operation words go in through the valid/ready input channel and a shadow
// copy of the capture state predicts every result word. Each result is
// checked field by field. The run covers every trigger code, the interval
// extremes, restarts, reads past the count and a long receiver hold-off,
// under sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import tsc_pkg::*;

  // Trigger codes outside the defined set; both fire on the first due sample
  localparam logic [MODE_W-1:0] TRIG_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] TRIG_SPARE_B = 3'd7;

  localparam int STALL_LIMIT     = 5000;   // cycles with no word moving
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 400;    // long receiver stall
  localparam int BURST_WORDS     = 70;
  localparam int PRESSURE_TICKS  = 16;     // ticks offered during the hold-off

  localparam logic [IVL_W-1:0] IVL_FIELD_MAX = '1;
  localparam logic [IVL_W-1:0] IVL_RANGE_MAX = IVL_W'(1000000);
  localparam logic [IDX_W-1:0] IDX_TOP       = '1;

  typedef struct packed {
    op_t              operation;
    logic             pin_level;
    logic [IDX_W-1:0] read_index;
  } op_word_t;

  typedef struct packed {
    logic              capturing;
    logic              trigger_armed;
    logic [CNT_W-1:0]  entry_count;
    logic              auto_stopped;
    logic              read_valid;
    logic              read_level;
    logic [TIME_W-1:0] read_time;
  } status_word_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tsc_in_if  op_bus ();
  tsc_out_if res_bus ();

  triggered_sample_capture u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (op_bus),
    .result    (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and expectation stores
  op_word_t     pending_ops[$];
  status_word_t expected_status[$];

  // Stall control: percent of cycles in which each side idles
  int   src_idle_pct = 12;
  int   snk_idle_pct = 84;
  logic pressure_go = 1'b0;
  int   hold_count = 0;
  logic op_taken;

  // Bookkeeping
  int fail_count = 0;
  int stall_cycles = 0;
  int n_ops = 0;
  int n_results = 0;
  int n_valid_reads = 0;
  int n_trigger_fires = 0;
  int n_auto_stops = 0;

  // --------------------------------------------------------------------------
  // Shadow copy of the capture state
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] sh_stamp [DEPTH];
  logic              sh_level [DEPTH];
  int unsigned       sh_wptr;
  logic              sh_active;
  logic              sh_armed;
  logic              sh_prev_pin;
  logic [TIME_W-1:0] sh_last_stamp;
  logic [TIME_W-1:0] sh_now;
  logic [MODE_W-1:0] sh_mode;
  logic [IVL_W-1:0]  sh_interval;

  // Advance the shadow state by one operation word and return the result
  // word that the block must produce for it.
  function automatic status_word_t predict_capture(op_word_t w);
    status_word_t r;
    logic         fire;
    int unsigned  slot;
    r = '0;
    case (w.operation)
      OP_TICK: begin
        // Advance time first; the new value is the stamp that gets stored
        sh_now = sh_now + 1'b1;
        if (sh_active && TIME_W'(sh_now - sh_last_stamp) >= TIME_W'(sh_interval)) begin
          if (sh_mode != TRIG_NONE && !sh_armed) begin
            // The checked sample is dropped and keeps the interval reference
            case (sh_mode)
              TRIG_RISING:  fire = !sh_prev_pin && w.pin_level;
              TRIG_FALLING: fire = sh_prev_pin && !w.pin_level;
              TRIG_BOTH:    fire = sh_prev_pin != w.pin_level;
              TRIG_HIGH:    fire = w.pin_level;
              TRIG_LOW:     fire = !w.pin_level;
              default:      fire = 1'b1;
            endcase
            if (fire) begin
              sh_armed = 1'b1;
              n_trigger_fires++;
            end
            sh_prev_pin = w.pin_level;
          end else begin
            slot = sh_wptr % DEPTH;
            sh_stamp[slot] = sh_now;
            sh_level[slot] = w.pin_level;
            sh_wptr = (slot + 1) % DEPTH;
            sh_last_stamp = sh_now;
            sh_prev_pin = w.pin_level;
            // Stop on a full buffer, one entry short of the depth
            if (sh_wptr >= DEPTH - 1) begin
              sh_active = 1'b0;
              r.auto_stopped = 1'b1;
              n_auto_stops++;
            end
          end
        end
      end
      OP_START: begin
        sh_wptr = 0;
        sh_armed = (sh_mode == TRIG_NONE);
        sh_last_stamp = sh_now;
        sh_active = 1'b1;
      end
      OP_STOP: begin
        sh_active = 1'b0;
      end
      OP_READ: begin
        if (w.read_index < sh_wptr) begin
          r.read_valid = 1'b1;
          r.read_level = sh_level[w.read_index];
          r.read_time = sh_stamp[w.read_index];
        end
      end
    endcase
    r.capturing = sh_active;
    r.trigger_armed = sh_armed;
    r.entry_count = CNT_W'(sh_wptr);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer pending words, change inputs at the falling edge only
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ops
    op_word_t w;
    // Hold a word until it is taken; then advance or idle
    if (!rst && (!op_bus.valid || op_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        w = pending_ops.pop_front();
        op_bus.valid <= 1'b1;
        op_bus.operation <= w.operation;
        op_bus.pin_level <= w.pin_level;
        op_bus.read_index <= w.read_index;
      end else begin
        op_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold-off once pressure_go
  // is raised so that the block backs up and drops its input ready.
  always @(negedge clk) begin : drive_ready
    if (pressure_go && hold_count < HOLD_OFF_CYCLES) begin
      hold_count <= hold_count + 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare one field and record a mismatch
  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    op_word_t     seen;
    status_word_t predicted;
    status_word_t want;
    logic         moved;
    if (rst) begin
      op_taken <= 1'b0;
    end else begin
      moved = 1'b0;
      op_taken <= op_bus.valid && op_bus.ready;
      // Predict before checking so a word is queued before its result can show
      if (op_bus.valid && op_bus.ready) begin
        seen.operation = op_t'(op_bus.operation);
        seen.pin_level = op_bus.pin_level;
        seen.read_index = op_bus.read_index;
        predicted = predict_capture(seen);
        expected_status.insert(expected_status.size(), predicted);
        n_ops++;
        moved = 1'b1;
      end
      if (res_bus.valid && res_bus.ready) begin
        moved = 1'b1;
        n_results++;
        if (expected_status.size() == 0) begin
          $error("result word arrived with no operation outstanding");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (want.read_valid) n_valid_reads++;
          check_field("capturing", want.capturing, res_bus.capturing);
          check_field("trigger_armed", want.trigger_armed, res_bus.trigger_armed);
          check_field("entry_count", want.entry_count, res_bus.entry_count);
          check_field("auto_stopped", want.auto_stopped, res_bus.auto_stopped);
          check_field("read_valid", want.read_valid, res_bus.read_valid);
          check_field("read_level", want.read_level, res_bus.read_level);
          check_field("read_time", want.read_time, res_bus.read_time);
        end
      end
      // Watchdog: end the run if nothing moves for too long
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no word accepted on either channel for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(input op_t op, input logic pin, input logic [IDX_W-1:0] idx);
    op_word_t w;
    w.operation = op;
    w.pin_level = pin;
    w.read_index = idx;
    pending_ops.insert(pending_ops.size(), w);
  endtask

  // Write one register while the block is idle and mirror it in the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_TRIG_MODE) begin
      // A mode write re-arms only when no trigger is wanted
      sh_mode = data[MODE_W-1:0];
      sh_armed = (sh_mode == TRIG_NONE);
    end else begin
      sh_interval = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word is out and every result is back, then settle
  task automatic wait_idle();
    while (pending_ops.size() != 0 || op_bus.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a capture session: start, runs of ticks with sticky pin levels,
  // reads near the fill level; a share of stray starts, stops and noise.
  task automatic queue_capture_burst(input int n_words);
    int   made;
    int   pick;
    logic run_pin;
    made = 0;
    run_pin = $urandom_range(0, 1);
    if ($urandom_range(0, 3) != 0) begin
      queue_word(OP_START, $urandom_range(0, 1), IDX_W'($urandom()));
      made++;
    end
    while (made < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 9) < 3) run_pin = !run_pin;
        queue_word(OP_TICK, run_pin, IDX_W'($urandom()));
      end else if (pick < 75) begin
        queue_word(OP_READ, $urandom_range(0, 1), IDX_W'($urandom_range(0, 31)));
      end else if (pick < 80) begin
        queue_word(OP_READ, $urandom_range(0, 1), IDX_W'($urandom()));
      end else if (pick < 85) begin
        queue_word(OP_START, $urandom_range(0, 1), IDX_W'($urandom()));
      end else if (pick < 89) begin
        queue_word(OP_STOP, $urandom_range(0, 1), IDX_W'($urandom()));
      end else begin
        queue_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 1), IDX_W'($urandom()));
      end
      made++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    logic [MODE_W-1:0] mode_cycle [8];
    logic [CFG_W-1:0]  wdata;
    int                sel;

    mode_cycle = '{TRIG_NONE, TRIG_RISING, TRIG_FALLING, TRIG_BOTH,
                   TRIG_HIGH, TRIG_LOW, TRIG_SPARE_A, TRIG_SPARE_B};

    // Drive every input to a known value from time zero
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TRIG_MODE;
    cfg_data = '0;
    op_bus.valid = 1'b0;
    op_bus.operation = OP_TICK;
    op_bus.pin_level = 1'b0;
    op_bus.read_index = '0;
    res_bus.ready = 1'b0;
    op_taken = 1'b0;

    // Shadow state at reset; the store stays unwritten
    sh_wptr = 0;
    sh_active = 1'b0;
    sh_armed = 1'b0;
    sh_prev_pin = 1'b0;
    sh_last_stamp = '0;
    sh_now = '0;
    sh_mode = TRIG_NONE;
    sh_interval = IVL_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: reads of an empty buffer, stop while stopped, a tick
    // while stopped, then a start whose first tick is not yet due.
    queue_word(OP_READ, 1'b0, '0);
    queue_word(OP_READ, 1'b1, IDX_TOP);
    queue_word(OP_STOP, 1'b0, '0);
    queue_word(OP_TICK, 1'b1, IDX_TOP);
    queue_word(OP_START, 1'b0, '0);
    queue_word(OP_TICK, 1'b0, '0);
    queue_word(OP_READ, 1'b0, '0);
    wait_idle();

    // One tick per sample: store, read back, read past the count, restart
    // while running, and a tick after a stop.
    write_reg(CFG_SAMPLE_INTERVAL, CFG_W'(1));
    queue_word(OP_TICK, 1'b1, '0);
    queue_word(OP_TICK, 1'b0, '0);
    queue_word(OP_TICK, 1'b1, '0);
    queue_word(OP_READ, 1'b0, IDX_W'(0));
    queue_word(OP_READ, 1'b0, IDX_W'(2));
    queue_word(OP_READ, 1'b0, IDX_W'(3));
    queue_word(OP_START, 1'b0, '0);
    queue_word(OP_READ, 1'b0, IDX_W'(0));
    queue_word(OP_TICK, 1'b0, '0);
    queue_word(OP_STOP, 1'b0, '0);
    queue_word(OP_TICK, 1'b1, '0);
    queue_word(OP_READ, 1'b0, IDX_W'(0));
    wait_idle();

    // Rising trigger with a zero interval: every tick is due
    write_reg(CFG_TRIG_MODE, CFG_W'(TRIG_RISING));
    write_reg(CFG_SAMPLE_INTERVAL, '0);
    queue_word(OP_START, 1'b0, '0);
    queue_word(OP_TICK, 1'b1, '0);
    queue_word(OP_TICK, 1'b0, '0);
    queue_word(OP_TICK, 1'b1, '0);
    queue_word(OP_READ, 1'b0, IDX_W'(1));
    wait_idle();

    // Random sessions under three stall profiles. Capture may still be
    // running when the next mode is written, so the new trigger must wait.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          src_idle_pct = 12;
          snk_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          snk_idle_pct = 12;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        sel = pass * 5 + k;
        // Put junk in the bits above the mode field
        wdata = CFG_W'($urandom());
        wdata[MODE_W-1:0] = mode_cycle[sel % 8];
        write_reg(CFG_TRIG_MODE, wdata);
        if (sel == 3)
          wdata = IVL_FIELD_MAX;
        else if (sel == 9)
          wdata = IVL_RANGE_MAX;
        else if (sel % 5 == 1)
          wdata = '0;
        else
          wdata = CFG_W'($urandom_range(1, 4));
        write_reg(CFG_SAMPLE_INTERVAL, wdata);
        queue_capture_burst(BURST_WORDS);
        wait_idle();
      end
    end

    // Capture with no idling while the receiver holds off for a long
    // stretch, so the block backs up and stalls its input.
    write_reg(CFG_TRIG_MODE, CFG_W'(TRIG_NONE));
    write_reg(CFG_SAMPLE_INTERVAL, CFG_W'(1));
    pressure_go = 1'b1;
    queue_word(OP_START, 1'b0, '0);
    for (int i = 0; i < PRESSURE_TICKS; i++)
      queue_word(OP_TICK, $urandom_range(0, 1), IDX_W'($urandom()));
    queue_word(OP_READ, 1'b0, IDX_TOP - 1'b1);
    queue_word(OP_READ, 1'b1, IDX_TOP);
    queue_word(OP_READ, 1'b0, '0);
    queue_word(OP_READ, 1'b1, IDX_W'($urandom()));
    queue_word(OP_STOP, 1'b0, '0);
    wait_idle();

    $display("Coverage: %0d operation words, %0d result words, %0d valid reads.",
             n_ops, n_results, n_valid_reads);
    $display("Coverage: all eight trigger codes, %0d trigger fires, %0d buffer-full stops.",
             n_trigger_fires, n_auto_stops);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
